// File: src/pwct_pkg.sv
package pwct_pkg;

  // Fixed field widths of the channels
  localparam int CODE_W     = 16;
  localparam int CODE_IDX_W = 4;
  localparam int PREFIX_W   = 4;
  localparam int PFX_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_FIRST  = 3'd0,
    CFG_HDR_SECOND = 3'd1,
    CFG_ONE_FIRST  = 3'd2,
    CFG_ONE_SECOND = 3'd3,
    CFG_ZERO_FIRST = 3'd4,
    CFG_ZERO_SEC   = 3'd5,
    CFG_PREFIX     = 3'd6
  } cfg_idx_t;

endpackage

// File: src/pwct_if.sv
// Input channel: a tick or a start command with its code
interface pwct_in_if import pwct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CODE_W-1:0] send_value;

  modport source (output valid, output mode, output send_value, input ready);
  modport sink   (input valid, input mode, input send_value, output ready);
endinterface

// Result channel: line level and frame status after each item
interface pwct_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_end;

  modport source (output valid, output line_level, output busy_res, output frame_end,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input frame_end,
                  output ready);
endinterface

// Configuration write channel
interface pwct_cfg_if import pwct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/pulse_width_code_transmitter.sv
// The result of an accepted item is written into the output register as the item is taken.
// Throughput: one item per cycle; the state update is a single pass of logic
// between the state registers and the output register. A new item is taken in
// the same cycle that the waiting result leaves, and the input stalls while a
// result is held off by the receiver.
// Reset (rst_n low, synchronous): idle, line low, configuration cleared to zero.
module pulse_width_code_transmitter import pwct_pkg::*; #(
  parameter int FRAME_BITS = 20,
  parameter int TIME_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pwct_in_if.sink    in_chan,
  pwct_out_if.source out_chan,
  pwct_cfg_if.sink   cfg_chan
);

  localparam int POS_W = $clog2(FRAME_BITS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BITS - 1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HDR_B  = 3'd2,
    PH_FIRST  = 3'd3,
    PH_SECOND = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // Configuration registers
  logic [CFG_DATA_W-1:0] hdr_first_r, hdr_second_r;
  logic [CFG_DATA_W-1:0] one_first_r, one_second_r;
  logic [CFG_DATA_W-1:0] zero_first_r, zero_second_r;
  logic [PREFIX_W-1:0]   prefix_r;

  // Frame state
  phase_t                phase_r, phase_nxt;
  logic [POS_W-1:0]      bit_pos_r, bit_pos_nxt;
  logic                  bit_val_r, bit_val_nxt;
  logic                  line_r, line_nxt;
  logic [TIME_WIDTH-1:0] ticks_r, ticks_nxt;
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic                  frame_end_nxt;

  // Output register
  logic out_valid_r;
  logic line_level_r, busy_r, frame_end_r;

  logic             in_fire;
  logic             sel_bit;
  logic [POS_W-1:0] pfx_k;

  assign in_chan.ready       = !out_valid_r || out_chan.ready;
  assign in_fire             = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.line_level = line_level_r;
  assign out_chan.busy_res   = busy_r;
  assign out_chan.frame_end  = frame_end_r;

  // Pick the bit at the current position: code bits below, prefix bits above
  always_comb begin
    pfx_k = bit_pos_r - POS_W'(CODE_W);
    if (bit_pos_r >= POS_W'(CODE_W)) begin
      sel_bit = (pfx_k < POS_W'(PREFIX_W)) ? prefix_r[pfx_k[PFX_IDX_W-1:0]] : 1'b0;
    end else begin
      sel_bit = code_r[bit_pos_r[CODE_IDX_W-1:0]];
    end
  end

  // Next frame state for one accepted item
  always_comb begin
    phase_nxt     = phase_r;
    bit_pos_nxt   = bit_pos_r;
    bit_val_nxt   = bit_val_r;
    line_nxt      = line_r;
    ticks_nxt     = ticks_r;
    code_nxt      = code_r;
    frame_end_nxt = 1'b0;
    if (in_chan.mode) begin
      // Start: taken only in idle
      if (phase_r == PH_IDLE) begin
        code_nxt    = in_chan.send_value;
        bit_pos_nxt = POS_LAST;
        line_nxt    = !line_r;
        if (hdr_first_r != '0) begin
          phase_nxt = PH_HDR_B;
          ticks_nxt = TIME_WIDTH'(hdr_first_r);
        end else begin
          phase_nxt = PH_FIRST;
          ticks_nxt = TIME_WIDTH'(hdr_second_r);
        end
      end
    end else if (phase_r != PH_IDLE) begin
      if (ticks_r != '0) begin
        ticks_nxt = ticks_r - 1'b1;
      end else begin
        // Segment expired: advance the sequence
        unique case (phase_r)
          PH_HDR_B: begin
            line_nxt  = !line_r;
            phase_nxt = PH_FIRST;
            ticks_nxt = TIME_WIDTH'(hdr_second_r);
          end
          PH_FIRST: begin
            line_nxt    = !line_r;
            bit_val_nxt = sel_bit;
            phase_nxt   = PH_SECOND;
            ticks_nxt   = sel_bit ? TIME_WIDTH'(one_first_r) : TIME_WIDTH'(zero_first_r);
          end
          PH_SECOND: begin
            line_nxt  = !line_r;
            ticks_nxt = bit_val_r ? TIME_WIDTH'(one_second_r) : TIME_WIDTH'(zero_second_r);
            if (bit_pos_r != '0) begin
              bit_pos_nxt = bit_pos_r - 1'b1;
              phase_nxt   = PH_FIRST;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: begin
            line_nxt      = 1'b0;
            bit_pos_nxt   = POS_LAST;
            code_nxt      = '0;
            phase_nxt     = PH_IDLE;
            frame_end_nxt = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Hold state, configuration and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_pos_r     <= POS_LAST;
      bit_val_r     <= 1'b0;
      line_r        <= 1'b0;
      ticks_r       <= '0;
      code_r        <= '0;
      out_valid_r   <= 1'b0;
      hdr_first_r   <= '0;
      hdr_second_r  <= '0;
      one_first_r   <= '0;
      one_second_r  <= '0;
      zero_first_r  <= '0;
      zero_second_r <= '0;
      prefix_r      <= '0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          CFG_HDR_FIRST:  hdr_first_r   <= cfg_chan.data;
          CFG_HDR_SECOND: hdr_second_r  <= cfg_chan.data;
          CFG_ONE_FIRST:  one_first_r   <= cfg_chan.data;
          CFG_ONE_SECOND: one_second_r  <= cfg_chan.data;
          CFG_ZERO_FIRST: zero_first_r  <= cfg_chan.data;
          CFG_ZERO_SEC:   zero_second_r <= cfg_chan.data;
          CFG_PREFIX:     prefix_r      <= cfg_chan.data[PREFIX_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        bit_pos_r   <= bit_pos_nxt;
        bit_val_r   <= bit_val_nxt;
        line_r      <= line_nxt;
        ticks_r     <= ticks_nxt;
        code_r      <= code_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      line_level_r <= line_nxt;
      busy_r       <= (phase_nxt != PH_IDLE);
      frame_end_r  <= frame_end_nxt;
    end
  end

  // The line rests low whenever no frame is in progress
  a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !line_r)
    else $error("line high while idle");

  // A finished frame reports idle with the line low
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> (!line_level_r && !busy_r))
    else $error("frame end with busy or line high");

  // Bit position stays inside the frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_pos_r <= POS_LAST)
    else $error("bit position beyond frame");

  // A stalled result leaves the frame state untouched
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> ($stable(phase_r) && $stable(ticks_r)))
    else $error("state moved under a stalled result");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pwct_pkg::*;

  localparam int FRAME_BITS   = 20;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SETTLE_PAD   = 4;
  localparam int END_PAD      = 8;
  localparam int HOLD_LONG    = 200;
  localparam int STUCK_LIMIT  = 4000;
  localparam int REPORT_MAX   = 10;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // Index beyond the register list; writes to it must have no effect
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] send_value;
  } tx_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_end;
  } line_res_t;

  // Segment being timed: lead header, gap before a bit, first half of a bit, tail
  typedef enum logic [2:0] {
    TX_IDLE,
    TX_LEAD,
    TX_BIT_START,
    TX_BIT_MID,
    TX_TAIL
  } tx_phase_t;

  logic clk;
  logic rst_n;

  pwct_in_if  in_chan ();
  pwct_out_if out_chan ();
  pwct_cfg_if cfg_chan ();

  pulse_width_code_transmitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow of the timing registers and of the transmitter state
  logic [CFG_DATA_W-1:0] reg_copy [0:6];
  tx_phase_t             tx_phase;
  logic [4:0]            tx_pos;
  logic                  tx_bit;
  logic                  tx_line;
  logic [15:0]           tx_ticks;
  logic [CODE_W-1:0]     tx_code;

  tx_item_t  pending_items [$];
  line_res_t expected_lines [$];
  tx_item_t  cur_item;
  bit        holding;
  bit        calm;
  int        gap_left;
  int        stall_left;
  int        hold_left;
  int        lines_seen;
  int        items_in;
  int        frames_done;
  int        settings_loaded;
  int        random_items;
  int        mismatches;
  int        stuck;

  // Work out the line and frame status after one item
  function automatic line_res_t next_line(input logic mode, input logic [CODE_W-1:0] code);
    line_res_t r;
    logic      ended;
    int        k;
    ended = 1'b0;
    if (mode == MODE_START) begin
      if (tx_phase == TX_IDLE) begin
        tx_code = code;
        tx_pos  = 5'(FRAME_BITS - 1);
        tx_line = ~tx_line;
        if (reg_copy[CFG_HDR_FIRST] != 0) begin
          tx_phase = TX_LEAD;
          tx_ticks = reg_copy[CFG_HDR_FIRST];
        end else begin
          tx_phase = TX_BIT_START;
          tx_ticks = reg_copy[CFG_HDR_SECOND];
        end
      end
    end else if (tx_phase != TX_IDLE) begin
      if (tx_ticks != 0) begin
        tx_ticks = tx_ticks - 16'd1;
      end else begin
        case (tx_phase)
          TX_LEAD: begin
            tx_line  = ~tx_line;
            tx_phase = TX_BIT_START;
            tx_ticks = reg_copy[CFG_HDR_SECOND];
          end
          TX_BIT_START: begin
            tx_line = ~tx_line;
            if (tx_pos > 5'd15) begin
              k = int'(tx_pos) - 16;
              tx_bit = (k < PREFIX_W) ? reg_copy[CFG_PREFIX][k] : 1'b0;
            end else begin
              tx_bit = tx_code[tx_pos[CODE_IDX_W-1:0]];
            end
            tx_phase = TX_BIT_MID;
            tx_ticks = tx_bit ? reg_copy[CFG_ONE_FIRST] : reg_copy[CFG_ZERO_FIRST];
          end
          TX_BIT_MID: begin
            tx_line  = ~tx_line;
            tx_ticks = tx_bit ? reg_copy[CFG_ONE_SECOND] : reg_copy[CFG_ZERO_SEC];
            if (tx_pos > 0) begin
              tx_pos   = tx_pos - 5'd1;
              tx_phase = TX_BIT_START;
            end else begin
              tx_phase = TX_TAIL;
            end
          end
          TX_TAIL: begin
            tx_line  = 1'b0;
            tx_pos   = 5'(FRAME_BITS - 1);
            tx_code  = '0;
            tx_phase = TX_IDLE;
            ended    = 1'b1;
          end
          default: tx_phase = TX_IDLE;
        endcase
      end
    end
    r.line_level = tx_line;
    r.busy_res   = (tx_phase != TX_IDLE);
    r.frame_end  = ended;
    return r;
  endfunction

  // Driver: offer queued items, with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_lines.push_back(next_line(cur_item.mode, cur_item.send_value));
        items_in++;
        holding = 1'b0;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 12);
          in_chan.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding  = 1'b1;
          in_chan.valid      <= 1'b1;
          in_chan.mode       <= cur_item.mode;
          in_chan.send_value <= cur_item.send_value;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        lines_seen++;
        if (expected_lines.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected item: line %0b busy %0b end %0b", out_chan.line_level,
                     out_chan.busy_res, out_chan.frame_end);
          mismatches++;
        end else begin
          line_res_t want;
          want = expected_lines.pop_front();
          if (out_chan.line_level !== want.line_level || out_chan.busy_res !== want.busy_res ||
              out_chan.frame_end !== want.frame_end) begin
            if (mismatches < REPORT_MAX)
              $display("item %0d: expected line %0b busy %0b end %0b, got %0b %0b %0b",
                       lines_seen, want.line_level, want.busy_res, want.frame_end,
                       out_chan.line_level, out_chan.busy_res, out_chan.frame_end);
            mismatches++;
          end
          if (want.frame_end)
            frames_done++;
        end
        // Hold off for a long stretch so the block backs up into its input
        if (lines_seen == 250 || lines_seen == 800)
          hold_left = HOLD_LONG;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
                 (cfg_chan.valid && cfg_chan.ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", stuck);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    if (idx != CFG_UNUSED)
      reg_copy[idx] = val;
  endtask

  // Write all seven timing registers; junk rides above the four prefix bits
  task automatic load_timing(input logic [15:0] hf, input logic [15:0] hs,
                             input logic [15:0] of, input logic [15:0] os,
                             input logic [15:0] zf, input logic [15:0] zs,
                             input logic [PREFIX_W-1:0] pfx, input logic [11:0] junk);
    write_reg(CFG_HDR_FIRST, hf);
    write_reg(CFG_HDR_SECOND, hs);
    write_reg(CFG_ONE_FIRST, of);
    write_reg(CFG_ONE_SECOND, os);
    write_reg(CFG_ZERO_FIRST, zf);
    write_reg(CFG_ZERO_SEC, zs);
    write_reg(CFG_PREFIX, {junk, pfx});
    settings_loaded++;
  endtask

  // Queue a start and the ticks that carry its frame to the end
  task automatic queue_frame(input logic [CODE_W-1:0] code, input bit dup_start, input bit noisy);
    int   span;
    int   cut;
    logic b;
    span = (reg_copy[CFG_HDR_FIRST] != 0) ? int'(reg_copy[CFG_HDR_FIRST]) + 1 : 0;
    span += int'(reg_copy[CFG_HDR_SECOND]) + 1;
    for (int p = FRAME_BITS - 1; p >= 0; p--) begin
      if (p > 15)
        b = (p - 16 < PREFIX_W) ? reg_copy[CFG_PREFIX][p - 16] : 1'b0;
      else
        b = code[p];
      if (b)
        span += int'(reg_copy[CFG_ONE_FIRST]) + int'(reg_copy[CFG_ONE_SECOND]) + 2;
      else
        span += int'(reg_copy[CFG_ZERO_FIRST]) + int'(reg_copy[CFG_ZERO_SEC]) + 2;
    end
    if (noisy && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        pending_items.push_back(tx_item_t'{MODE_TICK, CODE_W'($urandom())});
    pending_items.push_back(tx_item_t'{MODE_START, code});
    if (dup_start)
      pending_items.push_back(tx_item_t'{MODE_START, ~code});
    // Cut some frames short so the next start lands while busy
    cut = (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(1, span / 2) : 0;
    for (int i = 0; i < span - cut; i++) begin
      if (noisy && $urandom_range(0, 39) == 0)
        pending_items.push_back(tx_item_t'{MODE_START, CODE_W'($urandom())});
      pending_items.push_back(tx_item_t'{MODE_TICK, CODE_W'($urandom())});
    end
    random_items += 1 + span - cut;
  endtask

  // Drain everything, finish any open frame with ticks, then pause
  task automatic settle();
    forever begin
      do @(posedge clk);
      while (pending_items.size() != 0 || holding || expected_lines.size() != 0);
      if (tx_phase == TX_IDLE)
        break;
      repeat (64) pending_items.push_back(tx_item_t'{MODE_TICK, CODE_W'($urandom())});
    end
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.mode        = MODE_TICK;
    in_chan.send_value  = '0;
    out_chan.ready      = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = CFG_HDR_FIRST;
    cfg_chan.data       = '0;
    for (int i = 0; i < 7; i++)
      reg_copy[i] = '0;
    tx_phase = TX_IDLE;
    tx_pos   = 5'(FRAME_BITS - 1);
    tx_bit   = 1'b0;
    tx_line  = 1'b0;
    tx_ticks = '0;
    tx_code  = '0;
    holding  = 1'b0;
    calm     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timings: no lead header, every segment one tick
    pending_items.push_back(tx_item_t'{MODE_TICK, 16'hFFFF});
    queue_frame(16'hFFFF, 1'b1, 1'b0);
    pending_items.push_back(tx_item_t'{MODE_TICK, 16'h0000});
    settle();

    // Lead header on, uneven halves, prefix with junk above it
    write_reg(CFG_UNUSED, 16'hFFFF);
    load_timing(16'd1, 16'd2, 16'd0, 16'd1, 16'd1, 16'd0, 4'hA, 12'hFFF);
    queue_frame(16'h0000, 1'b1, 1'b0);
    queue_frame(16'h8001, 1'b0, 1'b0);
    settle();
    load_timing(16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd3, 4'h5, 12'h000);
    queue_frame(16'h5AA5, 1'b0, 1'b0);
    settle();

    // Random timings, mostly well-formed frames with some noise
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      load_timing(($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 4)),
                  16'($urandom_range(0, 3)),
                  16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                  16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                  PREFIX_W'($urandom()), 12'($urandom()));
      repeat ($urandom_range(1, 4))
        queue_frame(CODE_W'($urandom()), 1'b0, ($urandom_range(0, 3) != 0));
      settle();
    end

    // Top-of-range segment times held in the halves that the frame never selects
    load_timing(16'd0, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 4'hF, 12'hFFF);
    queue_frame(16'hFFFF, 1'b0, 1'b0);
    settle();
    load_timing(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 4'h0, 12'h000);
    queue_frame(16'h0000, 1'b0, 1'b0);
    settle();

    // Last stretch without any idling
    calm <= 1'b1;
    load_timing(16'd2, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 4'h9, 12'h5A5);
    queue_frame(CODE_W'($urandom()), 1'b0, 1'b0);
    queue_frame(CODE_W'($urandom()), 1'b0, 1'b1);
    settle();

    repeat (END_PAD) @(posedge clk);
    if (expected_lines.size() != 0) begin
      $display("%0d expected items never arrived", expected_lines.size());
      mismatches += expected_lines.size();
    end
    $display("sent %0d items over %0d timing settings, %0d frames completed", items_in,
             settings_loaded, frames_done);
    $display("included busy restarts, idle ticks, long output hold-offs and full-range times");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
src/pwct_pkg.sv
src/pwct_if.sv
src/pulse_width_code_transmitter.sv
tb/tb.sv
